// ----- rtl/core/scaled_residual_add_macros.svh -----
// assertion helpers for the scaled residual add checks
`ifndef SCALED_RESIDUAL_ADD_MACROS_SVH
`define SCALED_RESIDUAL_ADD_MACROS_SVH

// same-cycle implication, masked during reset
`define SRA_CHECK(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("scaled_residual_add check failed");

// next-cycle implication, masked during reset
`define SRA_CHECK_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("scaled_residual_add check failed");

// next-cycle implication that also holds across reset
`define SRA_CHECK_RESET(label, pre, post) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("scaled_residual_add reset check failed");

`endif

// ----- rtl/core/sra_pkg.sv -----
package sra_pkg;

    // binary32 / bf16 special patterns
    localparam logic [31:0] QNAN32    = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG32 = 31'h7F80_0000;
    localparam logic [15:0] QNAN16    = 16'h7FC0;

    // format register codes
    localparam logic [1:0] MODE_F32  = 2'd0;
    localparam logic [1:0] MODE_BF16 = 2'd1;
    localparam logic [1:0] MODE_MIX  = 2'd2;

    // register index codes (decoded from paddr[2])
    localparam logic REG_SCALE  = 1'b0;
    localparam logic REG_FORMAT = 1'b1;

    // pipeline depth
    localparam int NUM_STAGES = 10;

endpackage

// ----- rtl/core/scaled_residual_add.sv -----
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------
// input     | in        | i_valid / o_stall  | i_addend_bits, i_scaled_bits, i_last_in
// output    | out       | o_valid / i_stall  | o_sum_bits, o_last_out
// config    | in        | psel/penable/pready| paddr, pwdata, prdata
//
// one element pair per cycle unless o_stall holds the input; ten register stages:
// multiplier, leading-zero count, normalize, round, align, add, count, normalize,
// round and bf16 narrow.
// reset is synchronous: clears all stage valid bits, scale to 1.0, format to f32.
// stall ripples back through the stages in the same cycle, so empty stages still
// fill while the output waits.
module scaled_residual_add (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_addend_bits,
    input  logic [31:0] i_scaled_bits,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sum_bits,
    output logic        o_last_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NS = sra_pkg::NUM_STAGES;

    typedef struct packed {
        logic [31:0]        a;
        logic [1:0]         mode;
        logic               last;
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic [47:0]        mant;
        logic signed [10:0] exp;
        logic [5:0]         lz;
    } t_norm_st;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] prod;
        logic [1:0]  mode;
        logic        last;
    } t_sum_in;

    typedef struct packed {
        logic [1:0]         mode;
        logic               last;
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign_big;
        logic               sign_small;
        logic [26:0]        ma;
        logic [26:0]        mb;
        logic signed [10:0] exp;
    } t_align_st;

    typedef struct packed {
        logic [1:0]  mode;
        logic        last;
        logic [31:0] res;
    } t_res_st;

    // configuration registers
    logic [31:0] r_scale;
    logic [1:0]  r_format;

    // pipeline registers
    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;
    t_norm_st  r_m0, r_m1, r_m2, n_m0, n_m1, n_m2;
    t_sum_in   r_p, n_p;
    t_align_st r_al, n_al;
    t_norm_st  r_as, r_a1, r_a2, n_as, n_a1, n_a2;
    t_res_st   r_rd, n_rd;
    logic [31:0] r_sum, n_sum;
    logic        r_last;

    // helpers
    function automatic logic is_nan(input logic [31:0] x);
        return x[30:0] > sra_pkg::INF_MAG32;
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:0] == sra_pkg::INF_MAG32;
    endfunction

    // {biased exponent (subnormal as 1), significand with hidden bit}
    function automatic logic [31:0] unpack(input logic [31:0] x);
        logic [7:0] ef;
        ef = x[30:23];
        return {((ef == 8'd0) ? 8'd1 : ef), (ef != 8'd0), x[22:0]};
    endfunction

    // highest set bit position as a leading-zero count
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    // round to nearest even from a significand normalized at bit 47
    function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] e,
                                               input logic [47:0] s);
        logic [10:0] sh;
        logic [47:0] sv;
        logic [7:0]  ef;
        logic [23:0] m;
        logic [23:0] rem;
        logic        up;
        logic [30:0] mag;
        sh = '0;
        sv = s;
        ef = e[7:0];
        if (e < 11'sd1) begin
            sh = 11'(11'sd1 - e);
            ef = 8'd1;
            if (sh >= 11'd48) begin
                sv = {47'b0, |s};
            end else begin
                sv = (s >> sh[5:0]) | {47'b0, |(s & ~({48{1'b1}} << sh[5:0]))};
            end
        end
        m   = sv[47:24];
        rem = sv[23:0];
        up  = (rem > 24'h80_0000) || ((rem == 24'h80_0000) && m[0]);
        mag = {ef - 8'd1, 23'b0} + {7'b0, m} + {30'b0, up};
        if (e >= 11'sd255) begin
            return {sign, sra_pkg::INF_MAG32};
        end
        return {sign, mag};
    endfunction

    // apb register file
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sra_pkg::REG_FORMAT) ? {30'b0, r_format} : r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 32'h3F80_0000;
            r_format <= sra_pkg::MODE_F32;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                sra_pkg::REG_SCALE:  r_scale  <= pwdata;
                sra_pkg::REG_FORMAT: r_format <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // stage advance chain, from the output back to the input
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 0: format select, multiply specials and significand product
    always_comb begin
        logic [31:0] a_in, b_in, ub, us;
        logic        sg;
        a_in = (r_format == sra_pkg::MODE_BF16) ? {i_addend_bits[15:0], 16'b0} : i_addend_bits;
        b_in = (r_format == sra_pkg::MODE_BF16 || r_format == sra_pkg::MODE_MIX)
             ? {i_scaled_bits[15:0], 16'b0} : i_scaled_bits;
        sg = b_in[31] ^ r_scale[31];
        ub = unpack(b_in);
        us = unpack(r_scale);
        n_m0          = '0;
        n_m0.a        = a_in;
        n_m0.mode     = r_format;
        n_m0.last     = i_last_in;
        n_m0.sign     = sg;
        n_m0.mant     = ub[23:0] * us[23:0];
        n_m0.exp      = $signed({3'b0, ub[31:24]}) + $signed({3'b0, us[31:24]}) - 11'sd126;
        if (is_nan(b_in) || is_nan(r_scale)) begin
            n_m0.spec     = 1'b1;
            n_m0.spec_val = sra_pkg::QNAN32;
        end else if (is_inf(b_in) || is_inf(r_scale)) begin
            n_m0.spec     = 1'b1;
            n_m0.spec_val = (b_in[30:0] == 31'b0 || r_scale[30:0] == 31'b0)
                          ? sra_pkg::QNAN32 : {sg, sra_pkg::INF_MAG32};
        end else if (b_in[30:0] == 31'b0 || r_scale[30:0] == 31'b0) begin
            n_m0.spec     = 1'b1;
            n_m0.spec_val = {sg, 31'b0};
        end
    end

    // stage 1: product leading-zero count
    always_comb begin
        n_m1    = r_m0;
        n_m1.lz = lzc48(r_m0.mant);
    end

    // stage 2: product normalize
    always_comb begin
        n_m2      = r_m1;
        n_m2.mant = r_m1.mant << r_m1.lz;
        n_m2.exp  = r_m1.exp - $signed({5'b0, r_m1.lz});
    end

    // stage 3: product round
    always_comb begin
        n_p.a    = r_m2.a;
        n_p.mode = r_m2.mode;
        n_p.last = r_m2.last;
        n_p.prod = r_m2.spec ? r_m2.spec_val : round_pack(r_m2.sign, r_m2.exp, r_m2.mant);
    end

    // stage 4: add specials, swap and align
    always_comb begin
        logic [31:0] x, y, ux, uy, ubig, usml;
        logic        swap;
        logic [7:0]  d;
        logic [26:0] mbr;
        x    = r_p.a;
        y    = r_p.prod;
        ux   = unpack(x);
        uy   = unpack(y);
        swap = ux[31:24] < uy[31:24];
        ubig = swap ? uy : ux;
        usml = swap ? ux : uy;
        d    = ubig[31:24] - usml[31:24];
        mbr  = {usml[23:0], 3'b0};
        n_al            = '0;
        n_al.mode       = r_p.mode;
        n_al.last       = r_p.last;
        n_al.sign_big   = swap ? y[31] : x[31];
        n_al.sign_small = swap ? x[31] : y[31];
        n_al.ma         = {ubig[23:0], 3'b0};
        n_al.exp        = $signed({3'b0, ubig[31:24]}) + 11'sd1;
        if (d >= 8'd27) begin
            n_al.mb = {26'b0, |mbr};
        end else begin
            n_al.mb = (mbr >> d[4:0]) | {26'b0, |(mbr & ~({27{1'b1}} << d[4:0]))};
        end
        if (is_nan(x) || is_nan(y)) begin
            n_al.spec     = 1'b1;
            n_al.spec_val = sra_pkg::QNAN32;
        end else if (is_inf(x)) begin
            n_al.spec     = 1'b1;
            n_al.spec_val = (is_inf(y) && (x[31] != y[31])) ? sra_pkg::QNAN32 : x;
        end else if (is_inf(y)) begin
            n_al.spec     = 1'b1;
            n_al.spec_val = y;
        end
    end

    // stage 5: significand add or subtract
    always_comb begin
        logic [27:0] s;
        s         = '0;
        n_as      = '0;
        n_as.mode = r_al.mode;
        n_as.last = r_al.last;
        n_as.exp  = r_al.exp;
        n_as.spec     = r_al.spec;
        n_as.spec_val = r_al.spec_val;
        n_as.sign     = r_al.sign_big;
        if (r_al.sign_big == r_al.sign_small) begin
            s = {1'b0, r_al.ma} + {1'b0, r_al.mb};
            if (s == 28'b0 && !r_al.spec) begin
                n_as.spec     = 1'b1;
                n_as.spec_val = {r_al.sign_big, 31'b0};
            end
        end else if (r_al.ma == r_al.mb) begin
            if (!r_al.spec) begin
                n_as.spec     = 1'b1;
                n_as.spec_val = 32'b0;
            end
        end else if (r_al.ma > r_al.mb) begin
            s = {1'b0, r_al.ma - r_al.mb};
        end else begin
            s         = {1'b0, r_al.mb - r_al.ma};
            n_as.sign = r_al.sign_small;
        end
        n_as.mant = {s, 20'b0};
    end

    // stage 6: sum leading-zero count
    always_comb begin
        n_a1    = r_as;
        n_a1.lz = lzc48(r_as.mant);
    end

    // stage 7: sum normalize
    always_comb begin
        n_a2      = r_a1;
        n_a2.mant = r_a1.mant << r_a1.lz;
        n_a2.exp  = r_a1.exp - $signed({5'b0, r_a1.lz});
    end

    // stage 8: sum round
    always_comb begin
        n_rd.mode = r_a2.mode;
        n_rd.last = r_a2.last;
        n_rd.res  = r_a2.spec ? r_a2.spec_val : round_pack(r_a2.sign, r_a2.exp, r_a2.mant);
    end

    // stage 9: bf16 narrow
    always_comb begin
        logic [32:0] wide;
        wide = {1'b0, r_rd.res} + 33'h7FFF + {32'b0, r_rd.res[16]};
        if (r_rd.mode != sra_pkg::MODE_BF16) begin
            n_sum = r_rd.res;
        end else if (is_nan(r_rd.res)) begin
            n_sum = {16'b0, sra_pkg::QNAN16};
        end else begin
            n_sum = {16'b0, wide[31:16]};
        end
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (adv[0]) r_m0 <= n_m0;
        if (adv[1]) r_m1 <= n_m1;
        if (adv[2]) r_m2 <= n_m2;
        if (adv[3]) r_p  <= n_p;
        if (adv[4]) r_al <= n_al;
        if (adv[5]) r_as <= n_as;
        if (adv[6]) r_a1 <= n_a1;
        if (adv[7]) r_a2 <= n_a2;
        if (adv[8]) r_rd <= n_rd;
        if (adv[9]) begin
            r_sum  <= n_sum;
            r_last <= r_rd.last;
        end
    end

    assign o_valid    = r_vld[NS-1];
    assign o_sum_bits = r_sum;
    assign o_last_out = r_last;

endmodule

// ----- rtl/core/sra_checker.sv -----
`include "scaled_residual_add_macros.svh"

module sra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_sum_bits,
    input logic        o_last_out
);

    // a stalled result transaction holds
    `SRA_CHECK_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_sum_bits) && $stable(o_last_out))

    // input backpressure only when the output itself is blocked
    `SRA_CHECK(a_stall_cause, o_stall, o_valid && i_stall)

    // reset empties the pipeline
    `SRA_CHECK_RESET(a_reset_empty, !i_rst_n, !o_valid)

endmodule

bind scaled_residual_add sra_checker u_sra_checker (.*);

// ----- tb/scaled_residual_add_checker.sv -----
`timescale 1ns / 100ps

module scaled_residual_add_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [31:0] i_addend_bits,
    input  logic [31:0] i_scaled_bits,
    input  logic        i_last_in,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_sum_bits,
    input  logic        o_last_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_count,
    output int          sum_count
);

    typedef struct packed {
        logic [31:0] sum;
        logic        last;
    } sum_item_t;

    sum_item_t   sum_queue[$];
    logic [31:0] shadow_scale;
    logic [1:0]  shadow_mode;

    function automatic bit nan32(logic [31:0] x);
        return x[30:0] > sra_pkg::INF_MAG32;
    endfunction

    function automatic bit inf32(logic [31:0] x);
        return x[30:0] == sra_pkg::INF_MAG32;
    endfunction

    // exponent and significand with hidden bit, subnormals at exponent 1
    function automatic void unpack32(logic [31:0] x, output int e, output logic [63:0] s);
        if (x[30:23] == 8'd0) begin
            e = 1;
            s = {41'd0, x[22:0]};
        end else begin
            e = int'(x[30:23]);
            s = {40'd0, 1'b1, x[22:0]};
        end
    endfunction

    // s normalized with bit 62 set; round to nearest even and pack
    function automatic logic [31:0] pack_rne(logic sign, int e, logic [63:0] s);
        logic [63:0] m, rem, half;
        int          sh;
        half = 64'd1 << 38;
        if (e >= 255) return {sign, sra_pkg::INF_MAG32};
        if (e < 1) begin
            sh = 1 - e;
            if (sh >= 63) s = (s != 0) ? 64'd1 : 64'd0;
            else s = (s >> sh) | (((s & ((64'd1 << sh) - 1)) != 0) ? 64'd1 : 64'd0);
            e = 1;
        end
        m = s >> 39;
        rem = s & ((64'd1 << 39) - 1);
        if (rem > half || (rem == half && m[0])) m = m + 1;
        return {sign, 31'd0} | ((32'(e - 1) << 23) + m[31:0]);
    endfunction

    function automatic logic [31:0] mul32(logic [31:0] x, logic [31:0] y);
        logic        sign;
        int          ex, ey, e;
        logic [63:0] sx, sy, s;
        sign = x[31] ^ y[31];
        if (nan32(x) || nan32(y)) return sra_pkg::QNAN32;
        if (inf32(x) || inf32(y)) begin
            if (x[30:0] == 0 || y[30:0] == 0) return sra_pkg::QNAN32;
            return {sign, sra_pkg::INF_MAG32};
        end
        if (x[30:0] == 0 || y[30:0] == 0) return {sign, 31'd0};
        unpack32(x, ex, sx);
        unpack32(y, ey, sy);
        s = sx * sy;
        e = ex + ey - 111;
        while (s[62] == 1'b0) begin
            s = s << 1;
            e--;
        end
        return pack_rne(sign, e, s);
    endfunction

    function automatic logic [31:0] add32(logic [31:0] x, logic [31:0] y);
        logic        gx, gy, g, tg;
        int          ex, ey, e, d, te;
        logic [63:0] sx, sy, s, ts;
        gx = x[31];
        gy = y[31];
        if (nan32(x) || nan32(y)) return sra_pkg::QNAN32;
        if (inf32(x)) begin
            if (inf32(y) && gx != gy) return sra_pkg::QNAN32;
            return x;
        end
        if (inf32(y)) return y;
        unpack32(x, ex, sx);
        unpack32(y, ey, sy);
        sx = sx << 38;
        sy = sy << 38;
        if (ex < ey) begin
            te = ex; ts = sx; tg = gx;
            ex = ey; sx = sy; gx = gy;
            ey = te; sy = ts; gy = tg;
        end
        d = ex - ey;
        if (d >= 63) sy = (sy != 0) ? 64'd1 : 64'd0;
        else if (d > 0) sy = (sy >> d) | (((sy & ((64'd1 << d) - 1)) != 0) ? 64'd1 : 64'd0);
        if (gx == gy) begin
            s = sx + sy;
            g = gx;
            if (s == 0) return {g, 31'd0};
        end else begin
            // exact cancellation gives +0
            if (sx == sy) return 32'd0;
            if (sx > sy) begin
                s = sx - sy;
                g = gx;
            end else begin
                s = sy - sx;
                g = gy;
            end
        end
        e = ex + 1;
        while (s[62] == 1'b0) begin
            s = s << 1;
            e--;
        end
        return pack_rne(g, e, s);
    endfunction

    function automatic logic [31:0] residual_sum(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        logic [32:0] w;
        if (shadow_mode == sra_pkg::MODE_BF16) begin
            a = {a[15:0], 16'd0};
            b = {b[15:0], 16'd0};
        end else if (shadow_mode == sra_pkg::MODE_MIX) begin
            b = {b[15:0], 16'd0};
        end
        r = add32(a, mul32(b, shadow_scale));
        if (shadow_mode == sra_pkg::MODE_BF16) begin
            if (nan32(r)) return {16'd0, sra_pkg::QNAN16};
            w = {1'b0, r} + 33'h7FFF + {32'd0, r[16]};
            r = {16'd0, w[31:16]};
        end
        return r;
    endfunction

    assign pending_count = sum_queue.size();

    always @(posedge i_clk) begin
        sum_item_t want;
        if (!i_rst_n) begin
            shadow_scale <= 32'h3F80_0000;
            shadow_mode  <= sra_pkg::MODE_F32;
            sum_queue.delete();
            fail_count = 0;
            sum_count  = 0;
        end else begin
            // register writes apply after this edge
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == sra_pkg::REG_SCALE) shadow_scale <= pwdata;
                else shadow_mode <= pwdata[1:0];
            end
            // output transaction against oldest expectation
            if (o_valid && !i_stall) begin
                sum_count++;
                if (sum_queue.size() == 0) begin
                    $error("sum_bits: unexpected result %h", o_sum_bits);
                    fail_count++;
                end else begin
                    want = sum_queue.pop_front();
                    if (o_sum_bits !== want.sum) begin
                        $error("sum_bits: expected %h actual %h", want.sum, o_sum_bits);
                        fail_count++;
                    end
                    if (o_last_out !== want.last) begin
                        $error("last_out: expected %b actual %b", want.last, o_last_out);
                        fail_count++;
                    end
                end
            end
            // input transaction
            if (i_valid && !o_stall) begin
                want.sum  = residual_sum(i_addend_bits, i_scaled_bits);
                want.last = i_last_in;
                sum_queue.push_back(want);
            end
        end
    end
endmodule

// ----- tb/scaled_residual_add_tb.sv -----
`timescale 1ns / 100ps

module scaled_residual_add_tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_addend_bits = '0;
    logic [31:0] i_scaled_bits = '0;
    logic        i_last_in = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_sum_bits;
    logic        o_last_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending_count, sum_count;
    int cycle_count = 0;
    int sent_count = 0;
    bit calm_sink = 1'b0;
    bit hold_sink = 1'b0;
    bit calm_source = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    always #5 i_clk = ~i_clk;

    scaled_residual_add dut (.*);

    scaled_residual_add_checker checker_inst (.*);

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("scaled_residual_add test failed");
            $finish;
        end
    end

    // receiver stall: random, calm stretches and one long hold-off
    always @(posedge i_clk) begin
        if (hold_sink) i_stall <= 1'b1;
        else if (calm_sink) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 20);
    end

    task automatic reg_write(logic reg_sel, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one element transaction, with random idle gaps before it
    task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last);
        while (!calm_source && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_addend_bits <= a;
        i_scaled_bits <= b;
        i_last_in     <= last;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    // stop offering, wait for drain, then pipeline latency
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (sra_pkg::NUM_STAGES + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_f32();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = {1'($urandom_range(1)), 8'hFF, 23'd0};
            1: v = {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
            2: v = {1'($urandom_range(1)), 31'd0};
            3: v = {1'($urandom_range(1)), 8'd0, 23'($urandom)};
            4: v = {1'($urandom_range(1)), 8'($urandom_range(1, 20)), 23'($urandom)};
            5: v = {1'($urandom_range(1)), 8'($urandom_range(230, 254)), 23'($urandom)};
            default: v = {1'($urandom_range(1)), 8'($urandom_range(110, 140)), 23'($urandom)};
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_bf16();
        logic [31:0] w;
        w = pick_f32();
        return {16'($urandom), w[31:16]};
    endfunction

    task automatic random_items(logic [1:0] mode, int count);
        logic [31:0] a, b;
        repeat (count) begin
            a = (mode == sra_pkg::MODE_BF16) ? pick_bf16() : pick_f32();
            b = (mode == sra_pkg::MODE_F32) ? pick_f32() : pick_bf16();
            // occasionally use fully random bit patterns
            if ($urandom_range(15) == 0) a = $urandom;
            if ($urandom_range(15) == 0) b = $urandom;
            send_pair(a, b, ($urandom_range(7) == 0));
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (sent_count >= 300);
        @(posedge i_clk);
        hold_sink = 1'b1;
        repeat (60) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extremes and special values
        calm_source = 1'b1;
        calm_sink = 1'b1;
        send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b0);
        send_pair(32'h3F80_0000, 32'hBF80_0000, 1'b1);
        send_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_pair(32'h7F80_0000, 32'hFF80_0000, 1'b1);
        send_pair(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);
        send_pair(32'h0000_0001, 32'h8000_0001, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        drain();
        reg_write(sra_pkg::REG_SCALE, 32'h7F80_0000);
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pair(32'h3F80_0000, 32'h0000_0001, 1'b1);
        drain();
        reg_write(sra_pkg::REG_SCALE, 32'h0080_0000);
        reg_write(sra_pkg::REG_FORMAT, {30'd0, sra_pkg::MODE_BF16});
        send_pair(32'hFFFF_7F7F, 32'hABCD_0001, 1'b0);
        send_pair(32'h0000_7F80, 32'h0000_FF80, 1'b1);
        send_pair(32'h1234_3F80, 32'h0000_3F81, 1'b0);
        drain();
        reg_write(sra_pkg::REG_SCALE, 32'hFFFF_FFFF);
        reg_write(sra_pkg::REG_FORMAT, {30'd0, sra_pkg::MODE_MIX});
        send_pair(32'h3F80_0000, 32'hFFFF_3F80, 1'b0);
        drain();
        reg_write(sra_pkg::REG_SCALE, 32'h3F80_0000);
        reg_write(sra_pkg::REG_FORMAT, 32'd3);
        send_pair(32'h4000_0000, 32'h4040_0000, 1'b1);
        drain();
        calm_source = 1'b0;
        calm_sink = 1'b0;

        // random phases across modes and scales
        for (int ph = 0; ph < 8; ph++) begin
            logic [1:0] mode;
            mode = 2'(ph % 4);
            reg_write(sra_pkg::REG_FORMAT, {30'd0, mode});
            case (ph)
                0: reg_write(sra_pkg::REG_SCALE, 32'h3F80_0000);
                1: reg_write(sra_pkg::REG_SCALE, 32'h0000_0000);
                7: reg_write(sra_pkg::REG_SCALE, 32'hFF7F_FFFF);
                default: reg_write(sra_pkg::REG_SCALE, pick_f32());
            endcase
            calm_source = (ph == 3);
            calm_sink = (ph == 3);
            random_items((mode == 2'd3) ? sra_pkg::MODE_F32 : mode, 125);
            drain();
        end

        $display("sent %0d element pairs, checked %0d sums over f32, bf16, mixed modes",
                 sent_count, sum_count);
        $display("scales included one, zero, infinity, max negative and random values");
        if (fail_count == 0) $display("scaled_residual_add test passed");
        else $display("scaled_residual_add test failed");
        $finish;
    end
endmodule
